// ===== rtl/efs_pkg.sv =====
package efs_pkg;

    // Request codes
    typedef enum logic [2:0] {
        CMD_BUS_ERR  = 3'd0,
        CMD_ADDR_ERR = 3'd1,
        CMD_IRQ      = 3'd2,
        CMD_TRACE    = 3'd3,
        CMD_ILLEGAL  = 3'd4,
        CMD_TRAP     = 3'd5,
        CMD_DONE     = 3'd6,
        CMD_UNUSED   = 3'd7
    } efs_cmd_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_VEC_READ = 2'd1,
        KIND_HALT     = 2'd2
    } efs_kind_t;

    // Frame type carried from front to back
    typedef enum logic [1:0] {
        FRAME_SHORT = 2'd0,
        FRAME_FAULT = 2'd1,
        FRAME_HALT  = 2'd2
    } efs_frame_t;

    localparam int ZERO_WORDS_DEF  = 16;
    localparam int FIXED_WORDS     = 10;   // fault frame words before the zero fill
    localparam int SHORT_WORDS     = 4;    // short frame words
    localparam int ZERO_OFS_BASE   = 26;   // offset of the first zero word
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [31:0] FAULT_FRAME_BYTES = 32'd58;
    localparam logic [31:0] SHORT_FRAME_BYTES = 32'd8;
    localparam logic [7:0]  VEC_BUS_ERR       = 8'd2;
    localparam logic [7:0]  VEC_ADDR_ERR      = 8'd3;
    localparam logic [7:0]  VEC_TRACE         = 8'd9;
    localparam logic [3:0]  FMT_FAULT         = 4'h8;
    localparam logic [3:0]  FMT_SHORT         = 4'h0;

    typedef struct packed {
        efs_cmd_t    cmd;
        logic [15:0] status_reg;
        logic [31:0] program_counter;
        logic [31:0] super_stack;
        logic [7:0]  vector_number;
        logic [2:0]  interrupt_level;
        logic [31:0] fault_address;
        logic [7:0]  access_status;
        logic [15:0] output_buffer;
        logic [15:0] input_buffer;
        logic [15:0] prefetch_word;
    } efs_in_t;

    typedef struct packed {
        efs_kind_t   kind;
        logic [31:0] bus_address;
        logic [15:0] write_data;
        logic [15:0] new_status;
        logic [31:0] new_stack;
        logic        last;
    } efs_out_t;

    // Classified request, one queue entry
    typedef struct packed {
        efs_frame_t  frame;
        logic [15:0] nsr;
        logic [31:0] sp;
        logic [31:0] vec_addr;
        logic [15:0] sr;
        logic [31:0] pc;
        logic [15:0] fmt;
        logic [15:0] ssw;
        logic [31:0] faddr;
        logic [15:0] obuf;
        logic [15:0] ibuf;
        logic [15:0] pref;
    } efs_desc_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } efs_qstat_t;

    // Frame offsets of the fixed words, in write order
    function automatic logic [4:0] efs_fixed_ofs(input logic [3:0] idx);
        logic [4:0] ofs;
        case (idx)
            4'd0:    ofs = 5'd4;
            4'd1:    ofs = 5'd0;
            4'd2:    ofs = 5'd2;
            4'd3:    ofs = 5'd6;
            4'd4:    ofs = 5'd8;
            4'd5:    ofs = 5'd10;
            4'd6:    ofs = 5'd12;
            4'd7:    ofs = 5'd16;
            4'd8:    ofs = 5'd20;
            4'd9:    ofs = 5'd24;
            default: ofs = 5'd0;
        endcase
        return ofs;
    endfunction

endpackage

// ===== rtl/exception_frame_sequencer_unit.sv =====
// Channel    | Handshake                | Payload
// -----------+--------------------------+---------------------------
// request    | req_valid / req_stall    | req  (efs_pkg::efs_in_t)
// result     | rsp_valid / rsp_stall    | rsp  (efs_pkg::efs_out_t)
// vbr write  | cfg_we                   | cfg_wdata
//
// A fault frame is 10 + ZERO_WORDS writes and a vector read, a short frame four writes and
// a vector read, a double fault one halt. The back sequencer emits one result per cycle
// unless the queue is empty or rsp_stall holds the output; the front takes one request
// per cycle while the two-entry queue has room; sequence-done and unused codes give no result.
// Reset clears the fault flag, vector base, queue and output valid.
// rsp_stall holds the output register; the front keeps accepting until the queue fills.
module exception_frame_sequencer_unit #(
    parameter int ZERO_WORDS = efs_pkg::ZERO_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  efs_pkg::efs_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output efs_pkg::efs_out_t rsp,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);
    import efs_pkg::*;

    efs_qstat_t qstat;
    efs_desc_t  wr_desc;
    efs_desc_t  head;
    logic       push;
    logic       pop;

    efs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qstat     (qstat),
        .push      (push),
        .desc      (wr_desc)
    );

    efs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_desc (wr_desc),
        .pop     (pop),
        .head    (head),
        .qstat   (qstat)
    );

    efs_back #(
        .ZERO_WORDS (ZERO_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/efs_front.sv =====
module efs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  efs_pkg::efs_in_t  req,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  efs_pkg::efs_qstat_t qstat,
    output logic              push,
    output efs_pkg::efs_desc_t desc
);
    import efs_pkg::*;

    logic        fault_active_reg, fault_active_next;
    logic [31:0] vbr_reg;
    logic        accept;
    logic        is_fault;
    logic [7:0]  vec;
    logic [15:0] nsr;

    assign req_stall = qstat.full;
    assign accept    = req_valid && !qstat.full;
    assign is_fault  = (req.cmd == CMD_BUS_ERR) || (req.cmd == CMD_ADDR_ERR);
    assign push      = accept && (req.cmd != CMD_DONE) && (req.cmd != CMD_UNUSED);

    // Vector selection
    always_comb
    begin
        case (req.cmd)
            CMD_BUS_ERR:  vec = VEC_BUS_ERR;
            CMD_ADDR_ERR: vec = VEC_ADDR_ERR;
            CMD_TRACE:    vec = VEC_TRACE;
            default:      vec = req.vector_number;
        endcase
    end

    // New status: supervisor on, trace off, mask for interrupts
    always_comb
    begin
        nsr = (req.status_reg | 16'h2000) & 16'h7fff;
        if (req.cmd == CMD_IRQ)
        begin
            nsr[10:8] = req.interrupt_level;
        end
    end

    // Descriptor build
    always_comb
    begin
        desc.sr       = req.status_reg;
        desc.pc       = req.program_counter;
        desc.faddr    = req.fault_address;
        desc.obuf     = req.output_buffer;
        desc.ibuf     = req.input_buffer;
        desc.pref     = req.prefetch_word;
        desc.vec_addr = vbr_reg + {22'd0, vec, 2'b00};
        desc.fmt      = {(is_fault ? FMT_FAULT : FMT_SHORT), 2'b00, vec, 2'b00};
        desc.ssw      = {2'b00, !req.access_status[6], req.access_status[6],
                         req.access_status[4], req.access_status[3],
                         !req.access_status[5], !req.access_status[7],
                         5'd0, req.access_status[2:0]};
        if (is_fault && fault_active_reg)
        begin
            desc.frame = FRAME_HALT;
            desc.nsr   = req.status_reg;
            desc.sp    = req.super_stack;
        end
        else if (is_fault)
        begin
            desc.frame = FRAME_FAULT;
            desc.nsr   = nsr;
            desc.sp    = req.super_stack - FAULT_FRAME_BYTES;
        end
        else
        begin
            desc.frame = FRAME_SHORT;
            desc.nsr   = nsr;
            desc.sp    = req.super_stack - SHORT_FRAME_BYTES;
        end
    end

    // Fault-in-progress flag
    always_comb
    begin
        fault_active_next = fault_active_reg;
        if (accept && req.cmd == CMD_DONE)
        begin
            fault_active_next = 1'b0;
        end
        else if (accept && is_fault)
        begin
            fault_active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_active_reg <= 1'b0;
            vbr_reg          <= 32'd0;
        end
        else
        begin
            fault_active_reg <= fault_active_next;
            if (cfg_we)
            begin
                vbr_reg <= cfg_wdata;
            end
        end
    end

    a_fault_sets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_fault |=> fault_active_reg)
        else $error("fault flag not set after bus or address error");

    a_halt_only_in_fault: assert property (@(posedge clk) disable iff (!rst_n)
        push && desc.frame == FRAME_HALT |-> fault_active_reg)
        else $error("halt result without an active fault");

endmodule

// ===== rtl/efs_queue.sv =====
module efs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  efs_pkg::efs_desc_t  wr_desc,
    input  logic                pop,
    output efs_pkg::efs_desc_t  head,
    output efs_pkg::efs_qstat_t qstat
);
    import efs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    efs_desc_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("pop from empty queue");

endmodule

// ===== rtl/efs_back.sv =====
module efs_back #(
    parameter int ZERO_WORDS = efs_pkg::ZERO_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  efs_pkg::efs_desc_t  head,
    input  efs_pkg::efs_qstat_t qstat,
    output logic                pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output efs_pkg::efs_out_t   rsp
);
    import efs_pkg::*;

    localparam int LAST_STEP = FIXED_WORDS + ZERO_WORDS;      // vector read of a fault frame
    localparam int STEP_W    = $clog2(LAST_STEP + 1);
    localparam int OFS_W     = $clog2(ZERO_OFS_BASE + 2 * ZERO_WORDS);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] zero_idx;
    logic [OFS_W-1:0]  ofs;
    logic [OFS_W-1:0]  zero_ofs;
    logic [15:0]       fixed_data;
    logic              advance;
    efs_out_t          res;
    efs_out_t          rsp_reg;
    logic              rsp_valid_reg;

    assign advance   = !qstat.empty && (!rsp_valid_reg || !rsp_stall);
    assign pop       = advance && res.last;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Data of the fixed frame words
    always_comb
    begin
        case (step_reg[3:0])
            4'd0:    fixed_data = head.pc[15:0];
            4'd1:    fixed_data = head.sr;
            4'd2:    fixed_data = head.pc[31:16];
            4'd3:    fixed_data = head.fmt;
            4'd4:    fixed_data = head.ssw;
            4'd5:    fixed_data = head.faddr[31:16];
            4'd6:    fixed_data = head.faddr[15:0];
            4'd7:    fixed_data = head.obuf;
            4'd8:    fixed_data = head.ibuf;
            4'd9:    fixed_data = head.pref;
            default: fixed_data = 16'd0;
        endcase
    end

    assign zero_idx = step_reg - STEP_W'(FIXED_WORDS);
    assign zero_ofs = OFS_W'(ZERO_OFS_BASE) + (OFS_W'(zero_idx) << 1);

    // Result for the current step
    always_comb
    begin
        ofs             = OFS_W'(efs_fixed_ofs(step_reg[3:0]));
        res.kind        = KIND_WRITE;
        res.write_data  = fixed_data;
        res.new_status  = head.nsr;
        res.new_stack   = head.sp;
        res.last        = 1'b0;
        case (head.frame)
            FRAME_HALT:
            begin
                res.kind       = KIND_HALT;
                res.write_data = 16'd0;
                res.last       = 1'b1;
            end
            FRAME_SHORT:
            begin
                if (step_reg >= STEP_W'(SHORT_WORDS))
                begin
                    res.kind       = KIND_VEC_READ;
                    res.write_data = 16'd0;
                    res.last       = 1'b1;
                end
            end
            FRAME_FAULT:
            begin
                if (step_reg >= STEP_W'(LAST_STEP))
                begin
                    res.kind       = KIND_VEC_READ;
                    res.write_data = 16'd0;
                    res.last       = 1'b1;
                end
                else if (step_reg >= STEP_W'(FIXED_WORDS))
                begin
                    ofs            = zero_ofs;
                    res.write_data = 16'd0;
                end
            end
            default:
            begin
                res.kind       = KIND_VEC_READ;
                res.write_data = 16'd0;
                res.last       = 1'b1;
            end
        endcase
        case (res.kind)
            KIND_WRITE:    res.bus_address = head.sp + 32'(ofs);
            KIND_VEC_READ: res.bus_address = head.vec_addr;
            default:       res.bus_address = 32'd0;
        endcase
    end

    // Step counter
    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            step_next = res.last ? '0 : step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= res;
        end
    end

    // Only the vector read or a halt closes a request
    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.last == (rsp_reg.kind != KIND_WRITE)))
        else $error("last flag does not match result kind");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> step_reg == '0)
        else $error("step counter busy with empty queue");

endmodule

// ===== test/exception_frame_sequencer_unit_tb.sv =====
module exception_frame_sequencer_unit_tb;

    import efs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;    // longer than one fault frame
    localparam int HOLD_CYCLES   = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    efs_in_t     req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    efs_out_t    rsp;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    // Predictor state and pending bus operations
    logic        model_fault_active = 1'b0;
    logic [31:0] model_vbr = '0;
    efs_out_t    bus_ops_due[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_request = 1'b0;

    exception_frame_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void push_bus_op(input efs_kind_t k, input logic [31:0] addr,
                                        input logic [15:0] data, input logic [15:0] nsr,
                                        input logic [31:0] sp, input logic fin);
        efs_out_t op;
        op.kind        = k;
        op.bus_address = addr;
        op.write_data  = data;
        op.new_status  = nsr;
        op.new_stack   = sp;
        op.last        = fin;
        bus_ops_due.push_back(op);
    endfunction

    // Frame writes and vector fetch caused by one accepted request
    function automatic void predict_exception_entry(input efs_in_t r);
        logic [15:0] nsr;
        logic [31:0] sp;
        logic [7:0]  vec;
        logic [15:0] ssw;
        int          i;
        if (r.cmd == CMD_DONE)
        begin
            model_fault_active = 1'b0;
            return;
        end
        if (r.cmd == CMD_UNUSED)
            return;
        nsr = (r.status_reg | 16'h2000) & 16'h7fff;
        vec = r.vector_number;
        if (r.cmd == CMD_BUS_ERR || r.cmd == CMD_ADDR_ERR)
        begin
            // fault on top of a fault halts the processor
            if (model_fault_active)
            begin
                push_bus_op(KIND_HALT, '0, '0, r.status_reg, r.super_stack, 1'b1);
                return;
            end
            model_fault_active = 1'b1;
            vec = (r.cmd == CMD_BUS_ERR) ? VEC_BUS_ERR : VEC_ADDR_ERR;
            ssw = '0;
            ssw[2:0] = r.access_status[2:0];
            ssw[8]   = ~r.access_status[7];
            ssw[9]   = ~r.access_status[5];
            ssw[10]  = r.access_status[3];
            ssw[11]  = r.access_status[4];
            if (r.access_status[6])
                ssw[12] = 1'b1;
            else
                ssw[13] = 1'b1;
            sp = r.super_stack - FAULT_FRAME_BYTES;
            push_bus_op(KIND_WRITE, sp + 32'd4, r.program_counter[15:0], nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp, r.status_reg, nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd2, r.program_counter[31:16], nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd6, {FMT_FAULT, 2'b00, vec, 2'b00}, nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd8, ssw, nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd10, r.fault_address[31:16], nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd12, r.fault_address[15:0], nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd16, r.output_buffer, nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd20, r.input_buffer, nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd24, r.prefetch_word, nsr, sp, 1'b0);
            for (i = 0; i < ZERO_WORDS_DEF; i++)
                push_bus_op(KIND_WRITE, sp + 32'd26 + 32'(2 * i), '0, nsr, sp, 1'b0);
        end
        else
        begin
            if (r.cmd == CMD_IRQ)
                nsr[10:8] = r.interrupt_level;
            else if (r.cmd == CMD_TRACE)
                vec = VEC_TRACE;
            sp = r.super_stack - SHORT_FRAME_BYTES;
            push_bus_op(KIND_WRITE, sp + 32'd4, r.program_counter[15:0], nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp, r.status_reg, nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd2, r.program_counter[31:16], nsr, sp, 1'b0);
            push_bus_op(KIND_WRITE, sp + 32'd6, {FMT_SHORT, 2'b00, vec, 2'b00}, nsr, sp, 1'b0);
        end
        push_bus_op(KIND_VEC_READ, model_vbr + {22'b0, vec, 2'b00}, '0, nsr, sp, 1'b1);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        efs_out_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (bus_ops_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none got %p", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = bus_ops_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(rsp.kind));
                check_field("bus_address", want.bus_address, rsp.bus_address);
                check_field("write_data", 32'(want.write_data), 32'(rsp.write_data));
                check_field("new_status", 32'(want.new_status), 32'(rsp.new_status));
                check_field("new_stack", want.new_stack, rsp.new_stack);
                check_field("last", 32'(want.last), 32'(rsp.last));
            end
        end
    end

    // Receiver: random stall bursts, or one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 9) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic efs_in_t make_request(input efs_cmd_t c);
        efs_in_t r;
        r.cmd             = c;
        r.status_reg      = 16'($urandom);
        r.program_counter = $urandom;
        r.super_stack     = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 63)) : $urandom;
        r.vector_number   = 8'($urandom);
        r.interrupt_level = 3'($urandom);
        r.fault_address   = $urandom;
        r.access_status   = 8'($urandom);
        r.output_buffer   = 16'($urandom);
        r.input_buffer    = 16'($urandom);
        r.prefetch_word   = 16'($urandom);
        return r;
    endfunction

    function automatic efs_cmd_t pick_short_cmd();
        return efs_cmd_t'($urandom_range(CMD_IRQ, CMD_TRAP));
    endfunction

    function automatic efs_cmd_t pick_fault_cmd();
        return efs_cmd_t'($urandom_range(CMD_BUS_ERR, CMD_ADDR_ERR));
    endfunction

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_request(input efs_in_t item);
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predict_exception_entry(item);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (bus_ops_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vector_base(input logic [31:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_vbr = v;
    endtask

    // Vector fetch uses base 0 out of reset
    task automatic test_reset_vector_base();
        efs_in_t r;
        r = make_request(CMD_TRAP);
        r.vector_number = 8'h40;
        send_request(r);
    endtask

    // Short frames: level and status extremes, stack wrap
    task automatic test_short_frames();
        efs_in_t r;
        r = make_request(CMD_IRQ);
        r.interrupt_level = 3'd7;
        r.status_reg = 16'h0000;
        send_request(r);
        r = make_request(CMD_IRQ);
        r.interrupt_level = 3'd0;
        r.status_reg = 16'hffff;
        send_request(r);
        r = make_request(CMD_TRACE);
        r.status_reg = 16'h8700;
        send_request(r);
        r = make_request(CMD_ILLEGAL);
        r.vector_number = 8'h00;
        r.super_stack = 32'h0;
        r.program_counter = 32'h0;
        send_request(r);
        r = make_request(CMD_TRAP);
        r.vector_number = 8'hff;
        r.super_stack = 32'hffff_ffff;
        r.program_counter = 32'hffff_ffff;
        send_request(r);
    endtask

    // Fault frames, double faults, done and unused codes
    task automatic test_fault_frames();
        efs_in_t r;
        r = make_request(CMD_BUS_ERR);
        r.access_status = 8'h00;
        r.status_reg = 16'hffff;
        r.program_counter = 32'hffff_ffff;
        send_request(r);
        send_request(make_request(CMD_IRQ));
        send_request(make_request(CMD_BUS_ERR));
        send_request(make_request(CMD_ADDR_ERR));
        send_request(make_request(CMD_DONE));
        send_request(make_request(CMD_UNUSED));
        r = make_request(CMD_ADDR_ERR);
        r.access_status = 8'hff;
        r.super_stack = 32'h10;
        r.fault_address = 32'hffff_ffff;
        send_request(r);
        send_request(make_request(CMD_DONE));
        r = make_request(CMD_BUS_ERR);
        r.access_status = 8'h40;
        r.fault_address = 32'h0;
        send_request(r);
        send_request(make_request(CMD_DONE));
    endtask

    // Vector base extremes, table address wraps
    task automatic test_vector_base_writes();
        efs_in_t r;
        write_vector_base(32'hffff_ffff);
        r = make_request(CMD_TRAP);
        r.vector_number = 8'hff;
        send_request(r);
        send_request(make_request(CMD_TRACE));
        write_vector_base(32'h0000_1000);
        send_request(make_request(CMD_IRQ));
    endtask

    // Long receiver hold while the sender keeps offering
    task automatic test_output_backpressure();
        wait_idle();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        while (hold_request)
            @(posedge clk);
        send_request(make_request(pick_fault_cmd()));
        send_request(make_request(CMD_IRQ));
        send_request(make_request(CMD_TRAP));
        send_request(make_request(CMD_TRACE));
        send_request(make_request(CMD_DONE));
        send_request(make_request(pick_fault_cmd()));
        send_request(make_request(CMD_ILLEGAL));
        send_request(make_request(CMD_ILLEGAL));
        gaps_on = 1'b1;
    endtask

    // Mostly fault sequences closed by done, with short exceptions and noise
    task automatic test_random_traffic(input int item_goal, input bit quiet);
        int sent;
        int pick;
        gaps_on = !quiet;
        stalls_on = !quiet;
        sent = 0;
        while (sent < item_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_request(make_request(pick_fault_cmd()));
                sent++;
                repeat ($urandom_range(0, 3))
                begin
                    send_request(make_request(pick_short_cmd()));
                    sent++;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    send_request(make_request(pick_fault_cmd()));
                    sent++;
                end
                send_request(make_request(CMD_DONE));
                sent++;
            end
            else if (pick < 88)
            begin
                send_request(make_request(pick_short_cmd()));
                sent++;
            end
            else if (pick < 95)
            begin
                send_request(make_request(CMD_DONE));
                sent++;
            end
            else
            begin
                send_request(make_request(CMD_UNUSED));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_vector_base();
        test_short_frames();
        test_fault_frames();
        test_vector_base_writes();
        test_output_backpressure();
        write_vector_base($urandom);
        test_random_traffic(110, 1'b0);
        write_vector_base(32'hffff_fffc);
        test_random_traffic(110, 1'b0);
        write_vector_base($urandom);
        test_random_traffic(100, 1'b1);
        wait_idle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
